/* rtl/core/hav_pkg.sv */
// ----------------------------------------------------------------------------
// hav_pkg
// shared constants, types and helpers of the haversine distance core
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int CordicSteps = 24;
  localparam int RootSteps   = 32;
  localparam int StepW       = $clog2(CordicSteps);
  localparam int RootStepW   = $clog2(RootSteps);

  localparam logic [63:0] PiQ62      = 64'hC90FDAA22168C234;
  localparam logic [63:0] DegScale   = PiQ62 / 64'd1800000000;
  localparam logic [31:0] HalfPiQ30  = 32'((PiQ62 + (64'd1 << 32)) >> 33);
  localparam logic [31:0] OneQ30     = 32'h4000_0000;
  localparam logic [31:0] GainQ30    = 32'd652032874;
  localparam logic [31:0] TwoRadius  = 32'd1274200000;
  localparam logic [30:0] DistMax    = 31'd2001508680;
  localparam logic signed [31:0] LatLimit = 32'sd900000000;
  localparam logic signed [33:0] HalfTurn = 34'sd1800000000;
  localparam logic signed [33:0] FullTurn = 34'sd3600000000;

  // cordic working word: q30 with headroom
  typedef logic signed [33:0] cw_t;

  // atan(2^-i) in q30, rounded to nearest
  function automatic cw_t atan_q30(input int i);
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] term;
    begin
      if (i == 0) begin
        acc = PiQ62 >> 2;
      end else begin
        p = 64'd1 << (62 - i);
        acc = p;
        for (int k = 1; k < 32; k++) begin
          if (2 * i <= 62 && p != 0) begin
            p = p >> (2 * i);
            if (p != 0) begin
              term = p / 64'(2 * k + 1);
              if (k % 2 == 1) acc = acc - term;
              else acc = acc + term;
            end
          end
        end
      end
      atan_q30 = cw_t'((acc + (64'd1 << 31)) >> 32);
    end
  endfunction

  // one cordic cell's word set
  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
  } cord_t;

  // one root cell's word set; the partial root sits high until the last steps
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } root_t;

endpackage

/* rtl/core/hav_cordic_cell.sv */
// ----------------------------------------------------------------------------
// hav_cordic_cell
// one registered cordic micro-rotation, rotation or vectoring mode
// ----------------------------------------------------------------------------
module hav_cordic_cell (
  input  logic                      clk,
  input  logic                      vector_mode,
  input  logic [hav_pkg::StepW-1:0] shift,
  input  hav_pkg::cw_t              angle,
  input  hav_pkg::cord_t            d,
  output hav_pkg::cord_t            q
);
  import hav_pkg::*;

  cw_t dx, dy;
  logic up;
  cord_t q_next;

  assign dx = d.y >>> shift;
  assign dy = d.x >>> shift;
  assign up = vector_mode ? (d.y >= 0) : (d.z >= 0);

  always_comb begin
    if (up != vector_mode) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - angle;
    end else begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + angle;
    end
    if (vector_mode && !up) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - angle;
    end
    if (vector_mode && up) begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + angle;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule

/* rtl/core/hav_root_cell.sv */
// ----------------------------------------------------------------------------
// hav_root_cell
// one registered step of the digit-by-digit square root
// ----------------------------------------------------------------------------
module hav_root_cell (
  input  logic                          clk,
  input  logic [hav_pkg::RootStepW-1:0] step,
  input  hav_pkg::root_t                d,
  output hav_pkg::root_t                q
);
  import hav_pkg::*;

  logic [63:0] bitv, trial, res_w;
  root_t q_next;

  assign bitv  = 64'd1 << (7'd62 - 7'({step, 1'b0}));
  assign res_w = d.res;
  assign trial = res_w + bitv;

  always_comb begin
    if (d.v >= trial) begin
      q_next.v   = d.v - trial;
      q_next.res = (res_w >> 1) + bitv;
    end else begin
      q_next.v   = d.v;
      q_next.res = res_w >> 1;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule

/* rtl/core/haversine_distance_core.sv */
// ----------------------------------------------------------------------------
// haversine_distance_core
// great-circle distance between two points, one request per cycle
// ----------------------------------------------------------------------------
// A request (two latitude/longitude pairs in 1e-7 degree) is taken on any
// cycle where start is high; busy is always low, so a new request can enter
// every clock. The distance in centimetres appears on distance_cm with done
// high exactly one cycle. Stages: front end and radian scaling 2, four
// parallel rows of 24 cordic cells, 3 for the products and clamp, two rows of
// 32 root cells, 24 vectoring cells and 2 for the final scaling.
// The receiver cannot stall the result, so it must take done as it comes.
module haversine_distance_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] lat_a,
  input  logic signed [31:0] lon_a,
  input  logic signed [30:0] lat_b,
  input  logic signed [31:0] lon_b,
  output logic               done,
  output logic [30:0]        distance_cm
);
  import hav_pkg::*;

  localparam int Latency = 2 + CordicSteps + 3 + RootSteps + CordicSteps + 2;

  // valid tag travels alongside the data
  logic [Latency-1:0] vld;
  assign busy = 1'b0;

  // ---- stage 1: saturate, differences with longitude wrap, magnitudes
  logic signed [31:0] la_c, lb_c;
  logic signed [33:0] dlat_w, dlon_w, dlon_wr;
  logic [31:0] m_dlat, m_dlon, m_la, m_lb;

  function automatic logic signed [31:0] sat_lat(input logic signed [30:0] v);
    logic signed [31:0] e;
    begin
      e = 32'(v);
      if (e > LatLimit) sat_lat = LatLimit;
      else if (e < -LatLimit) sat_lat = -LatLimit;
      else sat_lat = e;
    end
  endfunction

  function automatic logic [31:0] mag(input logic signed [33:0] v);
    mag = v < 0 ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    la_c = sat_lat(lat_a);
    lb_c = sat_lat(lat_b);
    dlat_w = 34'(lb_c) - 34'(la_c);
    dlon_w = 34'(lon_b) - 34'(lon_a);
    if (dlon_w >= HalfTurn) dlon_wr = dlon_w - FullTurn;
    else if (dlon_w < -HalfTurn) dlon_wr = dlon_w + FullTurn;
    else dlon_wr = dlon_w;
  end

  always_ff @(posedge clk) begin
    m_dlat <= mag(dlat_w);
    m_dlon <= mag(dlon_wr);
    m_la   <= mag(34'(la_c));
    m_lb   <= mag(34'(lb_c));
  end

  // ---- stage 2: scale to q30 radians (half angles for the differences)
  function automatic cw_t to_ang(input logic [31:0] m, input logic half);
    logic [95:0] p;
    begin
      p = 96'(m) * 96'(DegScale);
      if (half) to_ang = cw_t'((p + (96'd1 << 32)) >> 33);
      else to_ang = cw_t'((p + (96'd1 << 31)) >> 32);
    end
  endfunction

  cord_t row_in [4];
  always_ff @(posedge clk) begin
    row_in[0] <= '{x: cw_t'(GainQ30), y: '0, z: to_ang(m_dlat, 1'b1)};
    row_in[1] <= '{x: cw_t'(GainQ30), y: '0, z: to_ang(m_dlon, 1'b1)};
    row_in[2] <= '{x: cw_t'(GainQ30), y: '0, z: to_ang(m_la, 1'b0)};
    row_in[3] <= '{x: cw_t'(GainQ30), y: '0, z: to_ang(m_lb, 1'b0)};
  end

  // ---- four rows of rotation cells
  cord_t rot [4][CordicSteps+1];
  for (genvar r = 0; r < 4; r++) begin : g_row
    assign rot[r][0] = row_in[r];
    for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
      hav_cordic_cell u_cell (
        .clk(clk), .vector_mode(1'b0), .shift(StepW'(i)),
        .angle(atan_q30(i)), .d(rot[r][i]), .q(rot[r][i+1])
      );
    end
  end

  function automatic logic [31:0] clamp01(input cw_t v);
    if (v < 0) clamp01 = '0;
    else if (v > cw_t'(OneQ30)) clamp01 = OneQ30;
    else clamp01 = 32'(v);
  endfunction

  // ---- products: squares and cosine product, then h
  logic [31:0] s_lat, s_lon, c_a, c_b;
  logic [31:0] sq_lat, sq_lon, cc;
  logic [63:0] prod;
  logic [31:0] sq_lat_d, h;
  assign s_lat = clamp01(rot[0][CordicSteps].y);
  assign s_lon = clamp01(rot[1][CordicSteps].y);
  assign c_a   = clamp01(rot[2][CordicSteps].x);
  assign c_b   = clamp01(rot[3][CordicSteps].x);

  logic [32:0] h_sum;
  always_ff @(posedge clk) begin
    sq_lat <= 32'((64'(s_lat) * 64'(s_lat)) >> 30);
    sq_lon <= 32'((64'(s_lon) * 64'(s_lon)) >> 30);
    cc     <= 32'((64'(c_a) * 64'(c_b)) >> 30);
    prod     <= 64'(cc) * 64'(sq_lon);
    sq_lat_d <= sq_lat;
    h <= (h_sum > 33'(OneQ30)) ? OneQ30 : 32'(h_sum);
  end
  assign h_sum = 33'(sq_lat_d) + 33'(prod >> 30);

  // ---- two rows of root cells: sqrt(h) and sqrt(1-h)
  root_t rt_h [RootSteps+1];
  root_t rt_r [RootSteps+1];
  assign rt_h[0] = '{v: 64'(h) << 30, res: '0};
  assign rt_r[0] = '{v: 64'(OneQ30 - h) << 30, res: '0};
  for (genvar n = 0; n < RootSteps; n++) begin : g_root
    hav_root_cell u_rh (.clk(clk), .step(RootStepW'(n)), .d(rt_h[n]), .q(rt_h[n+1]));
    hav_root_cell u_rr (.clk(clk), .step(RootStepW'(n)), .d(rt_r[n]), .q(rt_r[n+1]));
  end

  // ---- vectoring row: atan2(sqrt h, sqrt(1-h))
  cord_t vec [CordicSteps+1];
  assign vec[0] = '{x: cw_t'(rt_r[RootSteps].res), y: cw_t'(rt_h[RootSteps].res), z: '0};
  for (genvar i = 0; i < CordicSteps; i++) begin : g_vec
    hav_cordic_cell u_vcell (
      .clk(clk), .vector_mode(1'b1), .shift(StepW'(i)),
      .angle(atan_q30(i)), .d(vec[i]), .q(vec[i+1])
    );
  end

  // ---- scaling to centimetres
  logic [31:0] zc;
  logic [63:0] dist_w;
  cw_t zv;
  assign zv = vec[CordicSteps].z;
  always_ff @(posedge clk) begin
    if (zv < 0) zc <= '0;
    else if (zv > cw_t'(HalfPiQ30)) zc <= HalfPiQ30;
    else zc <= 32'(zv);
    distance_cm <= (dist_w > 64'(DistMax)) ? DistMax : 31'(dist_w);
  end
  assign dist_w = (64'(zc) * 64'(TwoRadius) + (64'd1 << 29)) >> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Latency-2:0], start};
    end
  end
  assign done = vld[Latency-1];

  // never refuses a request
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  // a valid tag reaching the end of the pipeline gives a strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(vld[Latency-2]) |-> done) else $error("done missing");
  // result is within range on every strobe
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> distance_cm <= DistMax) else $error("distance out of range");

endmodule

/* bench/tb_haversine_distance_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haversine_distance_core
// self-checking bench for the pipelined great-circle distance core
// ----------------------------------------------------------------------------
// Requests go in through start/busy, and a fixed-point predictor works out the
// expected distance for each accepted request. Results are strobed by done
// and compared in order. Directed corners come first, then random pairs under
// three idling patterns. Latitudes out of range and longitude differences
// that need wrapping are covered.
module tb_haversine_distance_core;
  import hav_pkg::*;

  localparam int FlushCycles = 100;
  localparam int WatchLimit  = 2000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [30:0] lat_a;
  logic signed [31:0] lon_a;
  logic signed [30:0] lat_b;
  logic signed [31:0] lon_b;
  logic               done;
  logic [30:0]        distance_cm;

  // expected distances, oldest first
  logic [30:0] dist_queue[$];
  int          fail_count;
  int          idle_cycles;
  int          send_idle_pct;
  longint      atan_tab[CordicSteps];

  haversine_distance_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .lat_a       (lat_a),
    .lon_a       (lon_a),
    .lat_b       (lat_b),
    .lon_b       (lon_b),
    .done        (done),
    .distance_cm (distance_cm)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // arithmetic shift right, rounding toward minus infinity
  function automatic longint floor_shift(input longint v, input int s);
    floor_shift = v >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    clip = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // 1e-7 degree magnitude to q30 radians; s = 33 gives the half angle
  function automatic longint deg_to_rad(input longint m, input int s);
    logic [63:0] prod;
    begin
      prod = 64'(m) * DegScale + (64'd1 << (s - 1));
      deg_to_rad = longint'(prod >> s);
    end
  endfunction

  function automatic void rotate_angle(input longint theta, output longint c,
                                       output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    begin
      x = longint'(GainQ30);
      y = 0;
      z = theta;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      c = x;
      s = y;
    end
  endfunction

  function automatic longint vector_angle(input longint xi, input longint yi);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    begin
      x = xi;
      y = yi;
      z = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_tab[i];
        end else begin
          x -= dx; y += dy; z -= atan_tab[i];
        end
      end
      vector_angle = z;
    end
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    begin
      res = 0;
      bitv = 64'd1 << 62;
      for (int n = 0; n < RootSteps; n++) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      int_sqrt = res;
    end
  endfunction

  function automatic logic [30:0] predict_distance(input logic signed [30:0] la,
      input logic signed [31:0] oa, input logic signed [30:0] lb,
      input logic signed [31:0] ob);
    longint pa;
    longint pb;
    longint dlat;
    longint dlon;
    longint cu;
    longint su;
    longint s_lat;
    longint s_lon;
    longint c_a;
    longint c_b;
    longint h;
    longint z;
    logic [63:0] prod;
    logic [63:0] r_h;
    logic [63:0] r_rest;
    logic [63:0] dist_cm;
    begin
      // latitudes saturate to the poles
      pa = clip(longint'(la), -longint'(LatLimit), longint'(LatLimit));
      pb = clip(longint'(lb), -longint'(LatLimit), longint'(LatLimit));
      dlat = pb - pa;
      dlon = longint'(ob) - longint'(oa);
      // wrap the longitude difference once
      if (dlon >= longint'(HalfTurn)) dlon -= longint'(FullTurn);
      else if (dlon < -longint'(HalfTurn)) dlon += longint'(FullTurn);
      rotate_angle(deg_to_rad(dlat < 0 ? -dlat : dlat, 33), cu, s_lat);
      rotate_angle(deg_to_rad(dlon < 0 ? -dlon : dlon, 33), cu, s_lon);
      rotate_angle(deg_to_rad(pa < 0 ? -pa : pa, 32), c_a, su);
      rotate_angle(deg_to_rad(pb < 0 ? -pb : pb, 32), c_b, su);
      s_lat = clip(s_lat, 0, longint'(OneQ30));
      s_lon = clip(s_lon, 0, longint'(OneQ30));
      c_a = clip(c_a, 0, longint'(OneQ30));
      c_b = clip(c_b, 0, longint'(OneQ30));
      prod = ((64'(c_a) * 64'(c_b)) >> 30) * ((64'(s_lon) * 64'(s_lon)) >> 30);
      h = longint'((64'(s_lat) * 64'(s_lat)) >> 30) + longint'(prod >> 30);
      h = clip(h, 0, longint'(OneQ30));
      r_h = int_sqrt(64'(h) << 30);
      r_rest = int_sqrt(64'(longint'(OneQ30) - h) << 30);
      z = clip(vector_angle(longint'(r_rest), longint'(r_h)), 0, longint'(HalfPiQ30));
      dist_cm = (64'(z) * 64'(TwoRadius) + (64'd1 << 29)) >> 30;
      if (dist_cm > 64'(DistMax)) dist_cm = 64'(DistMax);
      predict_distance = dist_cm[30:0];
    end
  endfunction

  // send one request, idling beforehand at the current rate
  task automatic send_request(input logic signed [30:0] la, input logic signed [31:0] oa,
                              input logic signed [30:0] lb, input logic signed [31:0] ob);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    lat_a <= la;
    lon_a <= oa;
    lat_b <= lb;
    lon_b <= ob;
    @(posedge clk);
    while (busy) @(posedge clk);
    dist_queue.push_back(predict_distance(la, oa, lb, ob));
    @(negedge clk);
  endtask

  // stop requesting and hold off until the pipeline has drained
  task automatic wait_drain();
    start <= 1'b0;
    while (dist_queue.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [30:0] rand_lat();
    rand_lat = 31'($signed($urandom_range(1800000000)) - 900000000);
  endfunction

  function automatic logic signed [31:0] rand_lon();
    rand_lon = 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
  endfunction

  // any 31/32-bit pattern, so every input bit toggles
  function automatic logic signed [30:0] raw_lat();
    raw_lat = 31'($urandom);
  endfunction

  task automatic test_corners();
    send_request(0, 0, 0, 0);
    send_request(31'sd900000000, 0, -31'sd900000000, 0);          // pole to pole
    send_request(0, 0, 0, 32'sd1800000000);                       // antipodal on equator
    send_request(0, -32'sd1800000000, 0, 32'sd1799999999);
    send_request(0, 32'sd1800000000, 0, -32'sd1800000000);        // wrap to zero
    send_request(31'sd900000000, 32'sd123, 31'sd900000000, -32'sd999);
    send_request(31'h3fffffff, 0, 31'h40000000, 0);               // saturated latitudes
    send_request(31'h40000000, 32'h7fffffff, 31'h3fffffff, 32'h80000000);
    send_request(0, 32'h7fffffff, 0, 32'h80000000);               // extreme longitude wrap
    send_request(1, 0, 0, 0);
    send_request(0, 0, 0, 1);
    send_request(31'sd450000000, 32'sd900000000, -31'sd450000000, -32'sd900000000);
    send_request(-31'sd899999999, 0, 31'sd899999999, 32'sd1800000000);
    send_request(31'sd515000000, -32'sd1200000, 31'sd407000000, -32'sd740000000);
    send_request(31'sd100, 32'sd100, 31'sd101, 32'sd101);         // tiny distance
    wait_drain();                                                 // pause for all results
  endtask

  task automatic test_random(input int count, input int idle_pct);
    int pick;
    logic signed [30:0] la;
    logic signed [31:0] oa;
    begin
      send_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
        pick = $urandom_range(9);
        la = rand_lat();
        oa = rand_lon();
        if (pick == 0) begin
          send_request(raw_lat(), 32'($urandom), raw_lat(), 32'($urandom));
        end else if (pick == 1) begin
          // nearby points
          send_request(la, oa, 31'(la + $signed($urandom_range(2000)) - 1000),
                       32'(oa + $signed($urandom_range(2000)) - 1000));
        end else if (pick == 2) begin
          // near-antipodal points
          send_request(la, oa, -la, 32'(oa + (oa < 0 ? 1800000000 : -1800000000)
                       + $signed($urandom_range(200)) - 100));
        end else begin
          send_request(la, oa, rand_lat(), rand_lon());
        end
      end
      wait_drain();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (dist_queue.size() == 0) begin
        $error("distance_cm: no request pending, got %0d", distance_cm);
        fail_count++;
      end else if (distance_cm !== dist_queue[0]) begin
        $error("distance_cm: expected %0d, actual %0d", dist_queue[0], distance_cm);
        fail_count++;
        void'(dist_queue.pop_front());
      end else begin
        void'(dist_queue.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CordicSteps; i++) atan_tab[i] = longint'(atan_q30(i));
    fail_count = 0;
    idle_cycles = 0;
    send_idle_pct = 37;
    rst = 1'b1;
    start = 1'b0;
    lat_a = '0;
    lon_a = '0;
    lat_b = '0;
    lon_b = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corners();
    test_random(650, 37);
    test_random(650, 71);
    test_random(650, 0);
    repeat (FlushCycles) @(negedge clk);
    if (fail_count == 0 && dist_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/hav_pkg.sv
rtl/core/hav_cordic_cell.sv
rtl/core/hav_root_cell.sv
rtl/core/haversine_distance_core.sv
bench/tb_haversine_distance_core.sv
